// ===== src/gat_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the generations automaton step block.
// No dependencies; every other file imports this package.
package gat_pkg;

   // Default sizes handed to the top level parameters
   localparam int DEF_MAX_SIDE  = 256;
   localparam int DEF_CELL_BITS = 8;

   // Field widths of the channels
   localparam int FUNC_W    = 2;
   localparam int COORD_W   = 8;
   localparam int VALUE_W   = 8;
   localparam int CHANGED_W = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 9;
   localparam int MASK_W    = 9;

   localparam logic [CHANGED_W-1:0] CHANGED_MAX = '1;

   // Item operation codes
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BIRTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SURVIVAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STATES   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT   = 3'd4;

   // Register reset values
   localparam logic [MASK_W-1:0] RST_BIRTH    = 9'd8;
   localparam logic [MASK_W-1:0] RST_SURVIVAL = 9'd12;
   localparam logic [7:0]        RST_STATES   = 8'd2;
   localparam logic [8:0]        RST_WIDTH    = 9'd240;
   localparam logic [8:0]        RST_HEIGHT   = 9'd240;

   // Sequencer states
   typedef enum logic [7:0] {
      ST_CLEAR      = 8'b0000_0001,
      ST_IDLE       = 8'b0000_0010,
      ST_ACCESS     = 8'b0000_0100,
      ST_GEN        = 8'b0000_1000,
      ST_GEN_DRAIN  = 8'b0001_0000,
      ST_COPY       = 8'b0010_0000,
      ST_COPY_DRAIN = 8'b0100_0000,
      ST_FINISH     = 8'b1000_0000
   } state_type;

endpackage

// ===== src/gat_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on gat_pkg for default widths.
module gat_ram import gat_pkg::*; #(
   parameter int AW = 16,
   parameter int DW = DEF_CELL_BITS
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem_ff [2**AW];
   logic [DW-1:0] rdata_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/gat_rule.sv =====
`timescale 1ns / 1ps
// Cell update rule: counts live neighbors in a 3x3 window and picks the next state.
// Depends on gat_pkg.
module gat_rule import gat_pkg::*; #(
   parameter int CELL_BITS = DEF_CELL_BITS
) (
   input  logic [2:0][2:0][CELL_BITS-1:0] win,   // [column][row], center at [1][1]
   input  logic [CELL_BITS-1:0]           top,
   input  logic [MASK_W-1:0]              birth_mask,
   input  logic [MASK_W-1:0]              survival_mask,
   output logic [CELL_BITS-1:0]           next_cell,
   output logic                           changed
);

   logic [3:0]           live;
   logic [CELL_BITS-1:0] center;
   logic [MASK_W-1:0]    mask;

   // Count live neighbors
   always_comb begin
      live = '0;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            if (!(c == 1 && r == 1) && win[c][r] == top) begin
               live = live + 4'd1;
            end
         end
      end
   end

   // Decay, birth, survival or death
   always_comb begin
      center = win[1][1];
      mask   = (center == '0) ? birth_mask : survival_mask;
      if (center != '0 && center < top) begin
         next_cell = center - CELL_BITS'(1);
      end else if (mask[live]) begin
         next_cell = top;
      end else if (center == '0) begin
         next_cell = '0;
      end else begin
         next_cell = top - CELL_BITS'(1);
      end
      changed = (next_cell != center);
   end

endmodule

// ===== src/generations_automaton_step.sv =====
`timescale 1ns / 1ps
// Generations automaton step: write cell, read cell, or advance one generation.
// Write and read items pass the access and finish states; the next item waits for idle.
// A generation reads the grid a column of three cells at a time through one RAM
// read port, then copies w*h cells back. After reset a clearing pass zeroes the
// grid RAM before items are taken.
module generations_automaton_step import gat_pkg::*; #(
   parameter int MAX_SIDE  = DEF_MAX_SIDE,
   parameter int CELL_BITS = DEF_CELL_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   // Request: tuser = func[1:0]
   // tdata = cell_x[7:0], cell_y[15:8], cell_value[23:16]
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,
   input  logic [FUNC_W-1:0]    req_tuser,
   // Response: tdata = read_value[7:0], changed_cells[24:8], zero pad[31:25]
   // tuser = out_of_range[0]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,
   output logic                 rsp_tuser,
   // Register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   localparam int IW     = $clog2(MAX_SIDE);
   localparam int AW     = 2 * IW;
   localparam int SW     = $clog2(MAX_SIDE + 1);
   localparam int EW     = (SW > 9) ? SW : 9;
   localparam int KW     = $clog2(MAX_SIDE + 2);
   localparam int NS_MAX = 1 << CELL_BITS;

   // Configuration registers
   logic [MASK_W-1:0] birth_ff, survival_ff;
   logic [7:0]        states_ff;
   logic [8:0]        width_ff, height_ff;

   state_type state_ff, state_in;

   // Latched request
   logic [FUNC_W-1:0]  func_ff;
   logic [COORD_W-1:0] x_ff, y_ff;
   logic [VALUE_W-1:0] val_ff;

   // Result registers
   logic [VALUE_W-1:0]   res_rv_ff;
   logic                 res_oor_ff;
   logic [CHANGED_W-1:0] chg_ff;
   logic                 rsp_valid_ff;
   logic [VALUE_W-1:0]   rsp_rv_ff;
   logic [CHANGED_W-1:0] rsp_chg_ff;
   logic                 rsp_oor_ff;

   // Sweep counters
   logic [AW-1:0] clr_ff;
   logic [IW-1:0] gy_ff, cx_ff, cy_ff;
   logic [KW-1:0] gk_ff;
   logic [1:0]    gr_ff;

   // Generation read pipeline
   logic          p1_valid_ff, p2_valid_ff;
   logic [1:0]    p1_gr_ff;
   logic [KW-1:0] p1_gk_ff;
   logic [IW-1:0] p1_gy_ff, p2_x_ff, p2_y_ff;
   logic [CELL_BITS-1:0] d0_ff, d1_ff;
   logic [2:0][2:0][CELL_BITS-1:0] win_ff;

   // Copy pipeline
   logic          c1_valid_ff;
   logic [AW-1:0] c1_addr_ff;

   // Effective sizes
   logic [EW-1:0]        gw_ext, gh_ext, eff_w, eff_h;
   logic [IW-1:0]        wm1, hm1;
   logic [KW-1:0]        kend;
   logic [8:0]           sc9, s9;
   logic [CELL_BITS-1:0] top;
   logic                 outside;

   always_comb begin
      gw_ext = EW'(width_ff);
      gh_ext = EW'(height_ff);
      eff_w  = (gw_ext < EW'(3)) ? EW'(3) : (gw_ext > EW'(MAX_SIDE)) ? EW'(MAX_SIDE) : gw_ext;
      eff_h  = (gh_ext < EW'(3)) ? EW'(3) : (gh_ext > EW'(MAX_SIDE)) ? EW'(MAX_SIDE) : gh_ext;
      wm1    = IW'(eff_w - EW'(1));
      hm1    = IW'(eff_h - EW'(1));
      kend   = KW'(eff_w + EW'(1));
      sc9    = {1'b0, states_ff};
      s9     = (sc9 < 9'd2) ? 9'd2 : (sc9 > 9'(NS_MAX)) ? 9'(NS_MAX) : sc9;
      top    = CELL_BITS'(s9 - 9'd1);
      outside = (EW'(x_ff) >= eff_w) || (EW'(y_ff) >= eff_h);
   end

   // Memories and rule
   logic                 cur_we, nxt_we;
   logic [AW-1:0]        cur_waddr, cur_raddr, nxt_waddr, nxt_raddr;
   logic [CELL_BITS-1:0] cur_wdata, cur_rdata, nxt_wdata, nxt_rdata;
   logic [CELL_BITS-1:0] rule_next, wval;
   logic                 rule_changed;
   logic [IW-1:0]        g_row, g_col;

   gat_ram #(.AW(AW), .DW(CELL_BITS)) u_cur (
      .clock(clock), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
      .raddr(cur_raddr), .rdata(cur_rdata)
   );

   gat_ram #(.AW(AW), .DW(CELL_BITS)) u_nxt (
      .clock(clock), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
      .raddr(nxt_raddr), .rdata(nxt_rdata)
   );

   gat_rule #(.CELL_BITS(CELL_BITS)) u_rule (
      .win(win_ff), .top(top), .birth_mask(birth_ff), .survival_mask(survival_ff),
      .next_cell(rule_next), .changed(rule_changed)
   );

   // Generation read address: row by sub-row, column by load index
   always_comb begin
      case (gr_ff)
         2'd0:    g_row = (gy_ff == '0) ? hm1 : gy_ff - IW'(1);
         2'd1:    g_row = gy_ff;
         default: g_row = (gy_ff == hm1) ? '0 : gy_ff + IW'(1);
      endcase
      if (gk_ff == '0) begin
         g_col = wm1;
      end else if (gk_ff == kend) begin
         g_col = '0;
      end else begin
         g_col = IW'(gk_ff - KW'(1));
      end
   end

   // Saturate written value
   always_comb begin
      if ({1'b0, val_ff} > 9'(top)) begin
         wval = top;
      end else begin
         wval = CELL_BITS'(val_ff);
      end
   end

   // Memory port selection
   always_comb begin
      cur_we    = 1'b0;
      cur_waddr = c1_addr_ff;
      cur_wdata = nxt_rdata;
      if (state_ff == ST_CLEAR) begin
         cur_we    = 1'b1;
         cur_waddr = clr_ff;
         cur_wdata = '0;
      end else if (state_ff == ST_ACCESS) begin
         cur_we    = (func_ff == FUNC_WRITE) && !outside;
         cur_waddr = {IW'(y_ff), IW'(x_ff)};
         cur_wdata = wval;
      end else if (c1_valid_ff) begin
         cur_we = 1'b1;
      end
      if (state_ff == ST_GEN) begin
         cur_raddr = {g_row, g_col};
      end else begin
         cur_raddr = {IW'(req_tdata[15:8]), IW'(req_tdata[7:0])};
      end
      nxt_we    = p2_valid_ff;
      nxt_waddr = {p2_y_ff, p2_x_ff};
      nxt_wdata = rule_next;
      nxt_raddr = {cy_ff, cx_ff};
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_ff == '1) state_in = ST_IDLE;
         ST_IDLE:   if (req_tvalid) state_in = ST_ACCESS;
         ST_ACCESS: state_in = (func_ff == FUNC_STEP) ? ST_GEN : ST_FINISH;
         ST_GEN: begin
            if (gr_ff == 2'd2 && gk_ff == kend && gy_ff == hm1) state_in = ST_GEN_DRAIN;
         end
         ST_GEN_DRAIN: if (!p1_valid_ff && !p2_valid_ff) state_in = ST_COPY;
         ST_COPY:       if (cx_ff == wm1 && cy_ff == hm1) state_in = ST_COPY_DRAIN;
         ST_COPY_DRAIN: state_in = ST_FINISH;
         ST_FINISH:     if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         c1_valid_ff  <= 1'b0;
         birth_ff     <= RST_BIRTH;
         survival_ff  <= RST_SURVIVAL;
         states_ff    <= RST_STATES;
         width_ff     <= RST_WIDTH;
         height_ff    <= RST_HEIGHT;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         // Register writes
         if (csr_valid) begin
            case (csr_index)
               REG_BIRTH:    birth_ff    <= csr_data;
               REG_SURVIVAL: survival_ff <= csr_data;
               REG_STATES:   states_ff   <= csr_data[7:0];
               REG_WIDTH:    width_ff    <= csr_data;
               REG_HEIGHT:   height_ff   <= csr_data;
               default: ;
            endcase
         end
         // Output register: load on finish, drop on transfer
         if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         p1_valid_ff <= (state_ff == ST_GEN);
         p2_valid_ff <= p1_valid_ff && (p1_gr_ff == 2'd2) && (p1_gk_ff >= KW'(2));
         c1_valid_ff <= (state_ff == ST_COPY);
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         func_ff <= req_tuser;
         x_ff    <= req_tdata[7:0];
         y_ff    <= req_tdata[15:8];
         val_ff  <= req_tdata[23:16];
      end

      // Resolve the access and arm the sweeps
      if (state_ff == ST_ACCESS) begin
         chg_ff     <= '0;
         res_oor_ff <= (func_ff == FUNC_WRITE || func_ff == FUNC_READ) && outside;
         if (func_ff == FUNC_READ && !outside) begin
            res_rv_ff <= VALUE_W'(cur_rdata);
         end else begin
            res_rv_ff <= '0;
         end
         gy_ff <= '0;
         gk_ff <= '0;
         gr_ff <= '0;
         cx_ff <= '0;
         cy_ff <= '0;
      end

      // Advance the generation read sweep
      if (state_ff == ST_GEN) begin
         if (gr_ff == 2'd2) begin
            gr_ff <= '0;
            if (gk_ff == kend) begin
               gk_ff <= '0;
               gy_ff <= gy_ff + IW'(1);
            end else begin
               gk_ff <= gk_ff + KW'(1);
            end
         end else begin
            gr_ff <= gr_ff + 2'd1;
         end
      end
      p1_gr_ff <= gr_ff;
      p1_gk_ff <= gk_ff;
      p1_gy_ff <= gy_ff;

      // Collect a column and shift the window
      if (p1_valid_ff) begin
         case (p1_gr_ff)
            2'd0: d0_ff <= cur_rdata;
            2'd1: d1_ff <= cur_rdata;
            default: begin
               win_ff[0] <= win_ff[1];
               win_ff[1] <= win_ff[2];
               win_ff[2] <= {cur_rdata, d1_ff, d0_ff};
            end
         endcase
      end
      p2_x_ff <= IW'(p1_gk_ff - KW'(2));
      p2_y_ff <= p1_gy_ff;

      // Count changed cells
      if (p2_valid_ff && rule_changed && chg_ff != CHANGED_MAX) begin
         chg_ff <= chg_ff + CHANGED_W'(1);
      end

      // Advance the copy sweep
      if (state_ff == ST_COPY) begin
         if (cx_ff == wm1) begin
            cx_ff <= '0;
            cy_ff <= cy_ff + IW'(1);
         end else begin
            cx_ff <= cx_ff + IW'(1);
         end
      end
      c1_addr_ff <= {cy_ff, cx_ff};

      // Hold the response payload
      if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_tready)) begin
         rsp_rv_ff  <= res_rv_ff;
         rsp_chg_ff <= (func_ff == FUNC_STEP) ? chg_ff : '0;
         rsp_oor_ff <= res_oor_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_chg_ff, rsp_rv_ff};
   assign rsp_tuser  = rsp_oor_ff;

endmodule

// ===== test/automaton_checker.sv =====
`timescale 1ns / 1ps
// Checker for the generations automaton step block: watches the request, response
// and register channels, predicts each response and compares it field by field.
// Depends on gat_pkg for field widths, operation codes and register indexes.
module automaton_checker import gat_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [23:0]          req_tdata,
   input  logic [FUNC_W-1:0]    req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [31:0]          rsp_tdata,
   input  logic                 rsp_tuser,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output int                   fail_count,
   output int                   pending_count,
   output int                   checked_count,
   output int                   gen_count
);

   typedef struct packed {
      logic [VALUE_W-1:0]   read_value;
      logic [CHANGED_W-1:0] changed_cells;
      logic                 out_of_range;
   } cell_result_type;

   // Shadow copy of the grid and the registers
   logic [7:0]           shadow_grid [0:65535];
   logic [7:0]           work_grid   [0:65535];
   logic [MASK_W-1:0]    birth_rule;
   logic [MASK_W-1:0]    survive_rule;
   logic [7:0]           num_states;
   logic [8:0]           cols_reg;
   logic [8:0]           rows_reg;
   cell_result_type      expected_results [$];

   function automatic int live_state();
      int s;
      s = num_states;
      if (s < 2) s = 2;
      if (s > 256) s = 256;
      return s - 1;
   endfunction

   function automatic int clamp_side(input logic [8:0] v);
      int r;
      r = v;
      if (r < 3) r = 3;
      if (r > 256) r = 256;
      return r;
   endfunction

   function automatic int is_live(input int x, input int y, input int top);
      return (shadow_grid[x + y * 256] == top) ? 1 : 0;
   endfunction

   // Compute one generation on the shadow grid, return the number of changed cells
   function automatic int advance_generation();
      int top, w, h, changed, x, y, xl, xr, yu, yd, u, v, n;
      logic [MASK_W-1:0] rule;
      top = live_state();
      w = clamp_side(cols_reg);
      h = clamp_side(rows_reg);
      changed = 0;
      for (y = 0; y < h; y++) begin
         yu = (y == 0) ? h - 1 : y - 1;
         yd = (y + 1 == h) ? 0 : y + 1;
         for (x = 0; x < w; x++) begin
            xl = (x == 0) ? w - 1 : x - 1;
            xr = (x + 1 == w) ? 0 : x + 1;
            u = shadow_grid[x + y * 256];
            if (u > 0 && u < top) begin
               v = u - 1;
            end else begin
               n = is_live(xl, yu, top) + is_live(x, yu, top) + is_live(xr, yu, top)
                 + is_live(xl, y, top) + is_live(xr, y, top)
                 + is_live(xl, yd, top) + is_live(x, yd, top) + is_live(xr, yd, top);
               rule = (u == 0) ? birth_rule : survive_rule;
               if (rule[n]) v = top;
               else v = (u == 0) ? 0 : top - 1;
            end
            work_grid[x + y * 256] = v[7:0];
            if (v != u && changed < 131071) changed++;
         end
      end
      for (y = 0; y < h; y++)
         for (x = 0; x < w; x++)
            shadow_grid[x + y * 256] = work_grid[x + y * 256];
      return changed;
   endfunction

   // Predict the response of one request transfer
   function automatic cell_result_type predict_cell_op(input logic [FUNC_W-1:0] op,
                                                      input logic [23:0] data);
      cell_result_type r;
      int x, y, val, top;
      logic outside;
      x = data[7:0];
      y = data[15:8];
      val = data[23:16];
      outside = (x >= clamp_side(cols_reg)) || (y >= clamp_side(rows_reg));
      r = '0;
      case (op)
         FUNC_WRITE: begin
            if (outside) begin
               r.out_of_range = 1'b1;
            end else begin
               top = live_state();
               if (val > top) val = top;
               shadow_grid[x + y * 256] = val[7:0];
            end
         end
         FUNC_STEP: begin
            r.changed_cells = advance_generation();
            gen_count++;
         end
         FUNC_READ: begin
            if (outside) r.out_of_range = 1'b1;
            else r.read_value = shadow_grid[x + y * 256];
         end
         default: ;
      endcase
      return r;
   endfunction

   initial begin
      fail_count = 0;
      pending_count = 0;
      checked_count = 0;
      gen_count = 0;
   end

   // Track registers, predict on request transfers, compare on response transfers
   always @(posedge clock) begin
      cell_result_type want;
      cell_result_type got;
      if (reset) begin
         for (int i = 0; i < 65536; i++) shadow_grid[i] = '0;
         birth_rule   = RST_BIRTH;
         survive_rule = RST_SURVIVAL;
         num_states   = RST_STATES;
         cols_reg     = RST_WIDTH;
         rows_reg     = RST_HEIGHT;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_BIRTH:    birth_rule   = csr_data;
               REG_SURVIVAL: survive_rule = csr_data;
               REG_STATES:   num_states   = csr_data[7:0];
               REG_WIDTH:    cols_reg     = csr_data;
               REG_HEIGHT:   rows_reg     = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_cell_op(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.read_value    = rsp_tdata[7:0];
            got.changed_cells = rsp_tdata[24:8];
            got.out_of_range  = rsp_tuser;
            if (expected_results.size() == 0) begin
               $display("%0t: response with nothing expected: tdata %h tuser %b",
                        $time, rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               checked_count++;
               if (got.read_value !== want.read_value) begin
                  $display("%0t: read_value expected %0d actual %0d",
                           $time, want.read_value, got.read_value);
                  fail_count++;
               end
               if (got.changed_cells !== want.changed_cells) begin
                  $display("%0t: changed_cells expected %0d actual %0d",
                           $time, want.changed_cells, got.changed_cells);
                  fail_count++;
               end
               if (got.out_of_range !== want.out_of_range) begin
                  $display("%0t: out_of_range expected %b actual %b",
                           $time, want.out_of_range, got.out_of_range);
                  fail_count++;
               end
               if (rsp_tdata[31:25] !== 7'd0) begin
                  $display("%0t: tdata pad expected 0 actual %h", $time, rsp_tdata[31:25]);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the generations automaton step testbench: clock, reset, stimulus and verdict.
// Depends on gat_pkg, the block generations_automaton_step and automaton_checker.
module testbench import gat_pkg::*;;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [23:0]          req_tdata = '0;
   logic [FUNC_W-1:0]    req_tuser = FUNC_READ;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = REG_BIRTH;
   logic [CSR_DAT_W-1:0] csr_data = '0;
   int                   fail_count, pending_count, checked_count, gen_count;
   int                   cycle_count = 0;
   int                   burst_left = 0;
   int                   stall_mode = 0;

   localparam int CYCLE_LIMIT = 2_000_000;

   always #6 clock = ~clock;

   generations_automaton_step u_top (.*);

   automaton_checker u_checker (.*);

   // Hold the run inside its cycle budget
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Stall the response side in a stall mode that is picked at random
   always @(posedge clock) begin
      if (cycle_count % 256 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0, 1: rsp_tready <= 1'b1;
         2: rsp_tready <= $urandom_range(0, 1);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Send one request, with bursts and random gaps between them
   task automatic send_op(input logic [FUNC_W-1:0] op, input int x, input int y, input int v);
      int gap;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {v[7:0], y[7:0], x[7:0]};
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
   endtask

   // Drain all responses before touching the registers
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DAT_W-1:0];
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_rules(input int birth, input int survive, input int states,
                            input int w, input int h);
      wait_idle();
      write_reg(REG_BIRTH, birth);
      write_reg(REG_SURVIVAL, survive);
      write_reg(REG_STATES, states);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
   endtask

   // Random traffic on the grid in use: mostly writes and reads, some generations
   task automatic random_ops(input int count, input int w, input int h);
      int pick, x, y;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 9) == 0) begin
            x = $urandom_range(0, 255);
            y = $urandom_range(0, 255);
         end else begin
            x = $urandom_range(0, w - 1);
            y = $urandom_range(0, h - 1);
         end
         if (pick < 50) send_op(FUNC_WRITE, x, y, $urandom_range(0, 255));
         else if (pick < 80) send_op(FUNC_READ, x, y, $urandom_range(0, 255));
         else if (pick < 97) send_op(FUNC_STEP, x, y, $urandom_range(0, 255));
         else send_op(2'd3, x, y, $urandom_range(0, 255));
      end
   endtask

   initial begin
      int w, h;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Default grid: plain access, edges, saturation, unknown operation
      send_op(FUNC_WRITE, 5, 5, 200);
      send_op(FUNC_READ, 5, 5, 0);
      send_op(FUNC_READ, 250, 3, 0);
      send_op(FUNC_WRITE, 7, 245, 1);
      send_op(FUNC_WRITE, 239, 239, 1);
      send_op(FUNC_READ, 239, 239, 0);
      send_op(2'd3, 255, 255, 255);

      // Blinker across the wrap edge on a small life grid
      set_rules(9'd8, 9'd12, 2, 5, 5);
      send_op(FUNC_WRITE, 4, 2, 1);
      send_op(FUNC_WRITE, 0, 2, 1);
      send_op(FUNC_WRITE, 1, 2, 1);
      send_op(FUNC_STEP, 0, 0, 0);
      send_op(FUNC_READ, 0, 1, 0);
      send_op(FUNC_STEP, 0, 0, 0);

      // Decaying states, then values left above the new top after lowering states
      set_rules(9'd8, 9'd12, 255, 3, 3);
      send_op(FUNC_WRITE, 0, 0, 254);
      send_op(FUNC_WRITE, 1, 1, 200);
      send_op(FUNC_WRITE, 2, 2, 5);
      set_rules(9'h1FF, 9'd0, 4, 3, 3);
      send_op(FUNC_STEP, 0, 0, 0);
      send_op(FUNC_READ, 1, 1, 0);
      send_op(FUNC_STEP, 0, 0, 0);

      // Oversized and undersized sides clamp; masks at both ends
      set_rules(9'd0, 9'h1FF, 0, 9'h1FF, 0);
      send_op(FUNC_WRITE, 255, 2, 1);
      send_op(FUNC_WRITE, 254, 0, 1);
      send_op(FUNC_STEP, 0, 0, 0);
      set_rules(9'h1FF, 9'h1FF, 1, 2, 256);
      send_op(FUNC_WRITE, 2, 255, 1);
      send_op(FUNC_READ, 3, 255, 0);
      send_op(FUNC_STEP, 0, 0, 0);

      // Random settings with random traffic on small grids
      for (int phase = 0; phase < 8; phase++) begin
         w = $urandom_range(3, 12);
         h = $urandom_range(3, 12);
         case (phase % 4)
            0: set_rules(9'd8, 9'd12, 2, w, h);
            1: set_rules($urandom_range(0, 511), $urandom_range(0, 511),
                         $urandom_range(2, 6), w, h);
            2: set_rules($urandom_range(0, 511), $urandom_range(0, 511),
                         $urandom_range(0, 255), w, h);
            default: set_rules(9'd4, 9'd6, $urandom_range(3, 9), w, h);
         endcase
         random_ops(8, w, h);
      end

      // Full-size access at the largest side, generations kept on a thin grid
      set_rules($urandom_range(0, 511), $urandom_range(0, 511), 255, 256, 3);
      for (int i = 0; i < 6; i++)
         send_op(i % 2 ? FUNC_READ : FUNC_WRITE, $urandom_range(0, 255),
                 $urandom_range(0, 7), $urandom_range(0, 255));
      send_op(FUNC_STEP, 0, 0, 0);

      wait_idle();
      repeat (20) @(posedge clock);
      $display("checked %0d responses, %0d of them generations, over 14 rule settings",
               checked_count, gen_count);
      if (fail_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
